>>> src/nptl_pkg.sv
// ----------------------------------------------------------------------------
// NAT port table package
// Shared constants, codes and item types for the port table learning block.
// ----------------------------------------------------------------------------
package nptl_pkg;

  // Table geometry. The depth may range from 2048 to 65536 entries.
  localparam int TABLE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  // Wide enough to hold an index one past the top entry of a full-size table.
  localparam int IDX_W       = 17;

  localparam logic [IDX_W-1:0] IDX_TOP   = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_WRAP  = IDX_W'(1001);
  localparam logic [IDX_W-1:0] IDX_FLOOR = IDX_W'(1000);

  localparam logic [15:0] PROBE_LIMIT = 16'd64535;

  // Division by 10000 as a multiplication by a rounded-up reciprocal.
  // The rounding error stays below one part in 8192 of the divisor step
  // over all 32-bit dividends, so the quotient is exact.
  localparam logic [31:0] DIV_RECIP = 32'd3518437209;
  localparam int          DIV_SHIFT = 45;
  localparam int          QUOT_W    = 64 - DIV_SHIFT;

  // Flow kinds.
  localparam logic [1:0] KIND_UDP = 2'd1;

  // Result codes.
  localparam logic [1:0] STATUS_NEW    = 2'd0;
  localparam logic [1:0] STATUS_EXISTS = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  typedef struct packed {
    logic [15:0] flow_id;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic [1:0]  kind;
  } req_t;

  typedef struct packed {
    logic [15:0] port;
    logic [1:0]  status;
  } res_t;

  // One table slot, filled flag in the top bit.
  typedef struct packed {
    logic        filled;
    logic [15:0] probe_dist;
    logic [15:0] flow_id;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> src/nptl_hash.sv
// ----------------------------------------------------------------------------
// NAT port table start index
// Two-stage pipeline: divide the source address by 10000, then add the
// identifier and swap the bytes of the 16-bit sum.
// ----------------------------------------------------------------------------
module nptl_hash
  import nptl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] src_ip,
  input  logic [15:0] flow_id,
  output logic        out_valid,
  output logic [15:0] start
);

  logic [63:0]       prod;
  logic [QUOT_W-1:0] quot;
  logic [15:0]       id_q;
  logic              valid_q;
  logic [15:0]       sum;

  assign prod = src_ip * DIV_RECIP;
  assign sum  = quot[15:0] + id_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_q   <= in_valid;
      out_valid <= valid_q;
    end
    quot  <= prod[63:DIV_SHIFT];
    id_q  <= flow_id;
    start <= {sum[7:0], sum[15:8]};
  end

endmodule

>>> src/nptl_probe.sv
// ----------------------------------------------------------------------------
// NAT port table probe engine
// Holds the slot memory, clears it after reset and walks the linear probe
// sequence for one request at a time, one slot per read and check pair.
// ----------------------------------------------------------------------------
module nptl_probe
  import nptl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  req_t req,
  output logic req_ready,
  output logic res_valid,
  output res_t res,
  input  logic res_ready
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_addr;
  req_t              req_q;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] cur;
  logic [15:0]       cnt;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rdata;
  logic               rd_en;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_data;

  logic              hash_valid;
  logic [15:0]       hash_start;
  logic [IDX_W-1:0]  adj_wrap;
  logic [IDX_W-1:0]  adj;
  entry_t            slot;
  logic              udp;
  logic              match;
  logic              accept;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  nptl_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .src_ip    (req.src_ip),
    .flow_id   (req.flow_id),
    .out_valid (hash_valid),
    .start     (hash_start)
  );

  // Wrap past the top, then lift anything under the floor.
  always_comb begin
    adj_wrap = (idx > IDX_TOP) ? IDX_WRAP : idx;
    adj      = (adj_wrap < IDX_FLOOR) ? (adj_wrap + IDX_FLOOR) : adj_wrap;
  end

  assign slot  = entry_t'(rdata);
  assign udp   = (req_q.kind == KIND_UDP);
  assign match = (slot.src_ip == req_q.src_ip) && (slot.dst_ip == req_q.dst_ip) &&
                 (!udp || (slot.flow_id == req_q.flow_id));
  assign rd_en = (state == ST_READ) && (cnt != PROBE_LIMIT);

  always_comb begin
    wr_en              = 1'b0;
    wr_addr            = cur;
    wr_data            = '0;
    wr_data.filled     = 1'b1;
    wr_data.probe_dist = udp ? slot.probe_dist : cnt;
    wr_data.flow_id    = req_q.flow_id;
    wr_data.dst_ip     = req_q.dst_ip;
    wr_data.src_ip     = req_q.src_ip;
    wr_data.src_mac    = req_q.src_mac;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (state == ST_CHECK && !slot.filled) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[adj[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {ADDR_W{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            req_q <= req;
            state <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (hash_valid) begin
            idx   <= IDX_W'(hash_start);
            cnt   <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (cnt == PROBE_LIMIT) begin
            res.status <= STATUS_FULL;
            res.port   <= '0;
            state      <= ST_DONE;
          end else begin
            cur   <= adj[ADDR_W-1:0];
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (slot.filled && match) begin
            res.status <= STATUS_EXISTS;
            res.port   <= 16'(cur);
            state      <= ST_DONE;
          end else if (slot.filled) begin
            idx   <= IDX_W'(cur) + IDX_W'(1);
            cnt   <= cnt + 16'd1;
            state <= ST_READ;
          end else begin
            res.status <= STATUS_NEW;
            res.port   <= 16'(cur);
            state      <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/nat_port_table_learning.sv
// Item path: an accepted item passes the hash stages, then one read and one check of
//   the slot memory for every slot probed, then the done state and the output register.
// Occupancy: one item at a time; the probe engine takes no new item until the last
//   has left its done state, each probe being one read and one check of the slot memory.
// Reset: synchronous; a clearing pass then writes every one of the 65536
//   slots, one per cycle, and no item is accepted until it ends.
// ----------------------------------------------------------------------------
// NAT port table learning
// Learns NAT translations in a linear-probing port table and returns, for
// each request, whether the flow was newly inserted, already present, or
// whether the table is full, together with the slot used as the port (zero when full).
// ----------------------------------------------------------------------------
module nat_port_table_learning
  import nptl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // src_mac [47:0], src_ip [79:48], dst_ip [111:80], flow_id [127:112]
  input  logic [127:0] s_tdata,
  // kind [1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // port [15:0]
  output logic [15:0]  m_tdata,
  // status [1:0]
  output logic [1:0]   m_tuser
);

  req_t req;
  res_t res;
  logic res_valid;
  logic res_ready;

  // The request item is the stream payload laid out field by field.
  assign req.src_mac = s_tdata[47:0];
  assign req.src_ip  = s_tdata[79:48];
  assign req.dst_ip  = s_tdata[111:80];
  assign req.flow_id = s_tdata[127:112];
  assign req.kind    = s_tuser;

  // The probe engine does all the table work. It takes a new item only when
  // it is idle, so every lookup and insert sees the writes of earlier items.
  nptl_probe u_probe (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req       (req),
    .req_ready (s_tready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register: a finished result waits here, which frees the engine
  // to take the next item while the downstream side is stalled.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      m_tdata <= res.port;
      m_tuser <= res.status;
    end
  end

`ifndef SYNTH
  // Inserted and found slots always lie at or above the floor of the table.
  a_port_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STATUS_FULL) |-> (m_tdata >= 16'd1000))
    else $error("result port below the table floor");

  // A full table reports port zero.
  a_full_port: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STATUS_FULL) |-> (m_tdata == 16'd0))
    else $error("table full result with a non-zero port");

  // The clearing pass keeps the input closed right after reset.
  a_clear_closed: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("item accepted during the clearing pass");

  // A result handed over by the engine appears on the output next cycle.
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> m_tvalid)
    else $error("engine result lost at the output register");
`endif

endmodule

>>> dv/nptl_flow_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAT port table flow checker
// Watches both streams of the port table learning block, keeps its own copy
// of the table, works out the result of every accepted request and compares
// it with the result the block returns.
// ----------------------------------------------------------------------------
module nptl_flow_checker
  import nptl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  // src_mac [47:0], src_ip [79:48], dst_ip [111:80], flow_id [127:112]
  input  logic [127:0] s_tdata,
  // kind [1:0]
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  // port [15:0]
  input  logic [15:0]  m_tdata,
  // status [1:0]
  input  logic [1:0]   m_tuser,
  output int           fail_count,
  output int           awaited
);

  entry_t port_table [TABLE_DEPTH];
  res_t   due_results [$];
  int     mismatches = 0;

  // Probes upward from the hashed start slot until a matching flow or a free
  // slot turns up or the probe limit runs out, learning the flow on a free slot.
  function automatic res_t learn_flow(input req_t r);
    logic [15:0] mix;
    logic [16:0] at;
    logic [15:0] hops;
    int unsigned probes;
    bit          settled;
    res_t        res;
    mix     = 16'(r.flow_id + r.src_ip / 32'd10000);
    at      = {1'b0, mix[7:0], mix[15:8]};
    hops    = '0;
    probes  = 0;
    settled = 1'b0;
    res.status = STATUS_FULL;
    res.port   = '0;
    while (!settled && probes < PROBE_LIMIT) begin
      if (at > IDX_TOP) at = IDX_WRAP;
      if (at < IDX_FLOOR) at = at + IDX_FLOOR;
      if (!port_table[at].filled) begin
        port_table[at].filled  = 1'b1;
        port_table[at].src_mac = r.src_mac;
        port_table[at].src_ip  = r.src_ip;
        port_table[at].dst_ip  = r.dst_ip;
        port_table[at].flow_id = r.flow_id;
        // UDP entries keep whatever distance the slot held before.
        if (r.kind != KIND_UDP) port_table[at].probe_dist = hops;
        res.status = STATUS_NEW;
        res.port   = at[15:0];
        settled    = 1'b1;
      end else if (port_table[at].src_ip == r.src_ip && port_table[at].dst_ip == r.dst_ip &&
                   (r.kind != KIND_UDP || port_table[at].flow_id == r.flow_id)) begin
        res.status = STATUS_EXISTS;
        res.port   = at[15:0];
        settled    = 1'b1;
      end else begin
        hops++;
        at++;
      end
      probes++;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    res_t due;
    if (rst) begin
      foreach (port_table[i]) port_table[i].filled = 1'b0;
      due_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: status %0d, port %0d", m_tuser, m_tdata);
          mismatches++;
        end else begin
          due = due_results.pop_front();
          if (m_tuser !== due.status) begin
            $error("status mismatch: expected %0d, actual %0d", due.status, m_tuser);
            mismatches++;
          end
          if (m_tdata !== due.port) begin
            $error("port mismatch: expected %0d, actual %0d", due.port, m_tdata);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) due_results.push_back(learn_flow(req_t'({s_tdata, s_tuser})));
    end
    fail_count <= mismatches;
    awaited    <= due_results.size();
  end

endmodule

>>> dv/nat_port_table_learning_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAT port table learning testbench
// Drives learn requests into the block: a directed opening, then random
// flows aimed mostly at a few crowded regions of the table, then a last
// repeat of the very first flow.
// Results are checked by the flow checker instantiated beside the block.
// ----------------------------------------------------------------------------
module nat_port_table_learning_test;
  import nptl_pkg::*;

  // Flow kinds other than UDP are only needed here.
  localparam logic [1:0] KIND_ICMP  = 2'd0;
  localparam logic [1:0] KIND_TCP   = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 750;
  localparam int HOLD_CYCLES  = 600;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [15:0]  m_tdata;
  logic [1:0]   m_tuser;

  int fail_count;
  int awaited;

  // Both sides idle at random while this is set; cleared for a calm stretch.
  bit idle_on = 1'b1;
  // Asks the receiver for its single long hold-off.
  bit hold_go = 1'b0;
  // Every request sent so far, so that flows can be repeated later.
  req_t learned [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  nat_port_table_learning dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  nptl_flow_checker flow_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  // The flow id that makes a request start probing at the given slot: the
  // hash is the byte swap of (id + src_ip / 10000), so undo the swap and take
  // the quotient back off.
  function automatic logic [15:0] id_for(input logic [15:0] slot, input logic [31:0] sip);
    return {slot[7:0], slot[15:8]} - 16'(sip / 32'd10000);
  endfunction

  function automatic req_t mk_flow(input logic [1:0] kind, input logic [47:0] mac,
                                   input logic [31:0] sip, input logic [31:0] dip,
                                   input logic [15:0] id);
    req_t r;
    r.kind    = kind;
    r.src_mac = mac;
    r.src_ip  = sip;
    r.dst_ip  = dip;
    r.flow_id = id;
    return r;
  endfunction

  // Start slots that crowd together, so that long probe chains build up.
  function automatic logic [15:0] hot_slot();
    case ($urandom_range(3))
      0: return 16'($urandom_range(20));             // below the floor, lifted by 1000
      1: return 16'($urandom_range(1030, 1000));
      2: return 16'($urandom_range(65535, 65520));   // runs off the top and wraps
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed traffic: repeats of learned flows, known address pairs
  // under a new id or kind, and new flows aimed at the crowded regions. The
  // remainder is entirely random.
  function automatic req_t random_flow();
    req_t        r;
    req_t        old;
    int unsigned roll;
    roll      = $urandom_range(99);
    r.kind    = 2'($urandom_range(3));
    r.src_mac = {16'($urandom), 32'($urandom)};
    r.src_ip  = $urandom;
    r.dst_ip  = $urandom;
    r.flow_id = 16'($urandom);
    if (learned.size() != 0 && roll < 40) begin
      old = learned[$urandom_range(learned.size() - 1)];
      if (roll < 20) begin
        r = old;
      end else begin
        r.src_ip  = old.src_ip;
        r.dst_ip  = old.dst_ip;
        r.flow_id = id_for(hot_slot(), r.src_ip);
      end
    end else if (roll < 75) begin
      r.flow_id = id_for(hot_slot(), r.src_ip);
    end
    return r;
  endfunction

  // Offers one item, with a random gap in front of it while idling is on,
  // and returns at the clock edge where it is accepted.
  task automatic send_item(input req_t r);
    while (idle_on && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    {s_tdata, s_tuser} <= r;
    learned.push_back(r);
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops offering and waits until every awaited result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  // Receiver: random stalls, plus one long hold-off on request so that the
  // block backs up and stops taking items.
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= !idle_on || ($urandom_range(99) >= 32);
      end
    end
  end

  initial begin : stimulus
    int unsigned k;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed opening. The block's own clearing pass after reset simply
    // shows up as a long wait for the first acceptance.
    send_item(mk_flow(KIND_ICMP, 48'h0, 32'h0, 32'h0, 16'h0));          // lands on 1000
    send_item(mk_flow(KIND_ICMP, 48'h0, 32'h0, 32'h0, 16'h0));          // found again
    // UDP with the same addresses but another port skips past slot 1000.
    send_item(mk_flow(KIND_UDP, '1, 32'h0, 32'h0, id_for(16'd1000, 32'h0)));
    send_item(mk_flow(KIND_UDP, '1, 32'h0, 32'h0, id_for(16'd1000, 32'h0)));
    // TCP and the spare kind match on the addresses alone.
    send_item(mk_flow(KIND_TCP, 48'h1, 32'h0, 32'h0, id_for(16'd1000, 32'h0)));
    send_item(mk_flow(KIND_SPARE, 48'h2, 32'h0, 32'h0, id_for(16'd1000, 32'h0)));
    // The top slot, then a second flow that must wrap round to 1001 and on.
    send_item(mk_flow(KIND_TCP, 48'h3, 32'd1, 32'd2, id_for(16'hffff, 32'd1)));
    send_item(mk_flow(KIND_ICMP, 48'h4, 32'd3, 32'd4, id_for(16'hffff, 32'd3)));
    // A start below the floor, then two starting on the lifted slot itself.
    send_item(mk_flow(KIND_UDP, 48'h5, 32'd5, 32'd6, id_for(16'd999, 32'd5)));
    send_item(mk_flow(KIND_TCP, 48'h6, 32'd7, 32'd8, id_for(16'd1999, 32'd7)));
    send_item(mk_flow(KIND_UDP, 48'h7, 32'd5, 32'd6, id_for(16'd1999, 32'd5)));
    // Field extremes.
    send_item(mk_flow(KIND_TCP, '1, '1, '1, '1));
    send_item(mk_flow(KIND_UDP, '1, '1, '1, '1));
    send_item(mk_flow(KIND_ICMP, '1, '1, 32'h0, 16'h0));
    send_item(mk_flow(KIND_UDP, 48'h0, 32'h0, '1, '1));

    // Random part, with the long receiver hold-off, two full pauses of the
    // sender and a calm stretch in which neither side idles.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      idle_on = !(k >= 300 && k < 450);
      if (k == 100) hold_go = 1'b1;
      if (k == 200 || k == 550) drain();
      send_item(random_flow());
    end
    drain();

    // The very first flow is still found after all the traffic.
    send_item(learned[0]);
    drain();

    repeat (32) @(posedge clk);
    if (fail_count == 0) begin
      $display("nat_port_table_learning regression: pass");
    end else begin
      $display("nat_port_table_learning regression: fail");
    end
    $finish;
  end

  // Guard against a hung block: far beyond the slowest correct run.
  initial begin : watchdog
    #(80_000_000);
    $display("nat_port_table_learning regression: fail");
    $finish;
  end

endmodule

>>> files.f
src/nptl_pkg.sv
src/nptl_hash.sv
src/nptl_probe.sv
src/nat_port_table_learning.sv
dv/nptl_flow_checker.sv
dv/nat_port_table_learning_test.sv
